// ===== design/great_circle_distance_top_macros.svh =====
// Assertion macros for the great circle distance block.
// Used by great_circle_distance_top; expects clk_i and rst_ni in scope.
`ifndef GREAT_CIRCLE_DISTANCE_TOP_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_TOP_MACROS_SVH

// Checked only outside reset
`define GCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included
`define GCD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/gcd_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table.
// No dependencies; used by the top module and the three cell modules.
package gcd_pkg;

  // datapath widths
  localparam int AW          = 34;
  localparam int DW          = 27;
  localparam int SQW         = 62;
  localparam int SQRT_STAGES = 31;

  typedef logic signed [AW-1:0] ang_t;
  typedef logic signed [DW-1:0] deg_t;

  // CORDIC cell state
  typedef struct packed {
    ang_t x;
    ang_t y;
    ang_t z;
  } cq_t;

  // square root cell state, with the cosine sum carried along
  typedef struct packed {
    logic [SQW-1:0]     v;
    logic [SQW-1:0]     res;
    logic signed [31:0] c;
  } sq_t;

  // flags that ride along the pipeline
  typedef struct packed {
    logic batch_end;
    logic zero;
    logic neg_a;
    logic neg_b;
    logic neg_d;
  } sb_t;

  // Q30 constants
  localparam ang_t ONE_Q30     = 34'sd1073741824;
  localparam ang_t PI_Q30      = 34'sd3373259426;
  localparam ang_t HALF_PI_Q30 = 34'sd1686629713;
  localparam ang_t GAIN_Q30    = 34'sd652032874;

  // degree fixed point, 1/65536 degree
  localparam deg_t FULL_TURN    = 27'sd23592960;
  localparam deg_t HALF_TURN    = 27'sd11796480;
  localparam deg_t QUARTER_TURN = 27'sd5898240;

  // pi/180 * 2^40 = 2^34 + DEG2RAD_LO
  localparam logic [30:0] DEG2RAD_LO = 31'd2010228885;
  localparam int          DEG2RAD_HI = 34;

  localparam logic [23:0] RADIUS_RESET = 24'd1630978;

  // atan(2^-i) in Q30
  function automatic ang_t atan_q30(input int unsigned i);
    ang_t r;
    r = '0;
    if (i < 10) begin
      unique case (i)
        0:       r = 34'sd843314857;
        1:       r = 34'sd497837829;
        2:       r = 34'sd263043837;
        3:       r = 34'sd133525159;
        4:       r = 34'sd67021687;
        5:       r = 34'sd33543516;
        6:       r = 34'sd16775851;
        7:       r = 34'sd8388437;
        8:       r = 34'sd4194283;
        default: r = 34'sd2097149;
      endcase
    end else if (i <= 30) begin
      r = ang_t'(34'sd1 <<< (30 - i));
    end
    return r;
  endfunction

endpackage

// ===== design/gcd_if.sv =====
// Valid/ready channel interfaces for coordinate items and distance items.
// Depends on nothing.
interface gcd_in_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] lon_a;
  logic signed [23:0] lat_a;
  logic signed [24:0] lon_b;
  logic signed [23:0] lat_b;
  logic               batch_end;

  modport source (output valid, lon_a, lat_a, lon_b, lat_b, batch_end, input ready);
  modport sink   (input valid, lon_a, lat_a, lon_b, lat_b, batch_end, output ready);
endinterface

interface gcd_out_if;
  logic        valid;
  logic        ready;
  logic [25:0] arc_distance;
  logic        batch_end_out;

  modport source (output valid, arc_distance, batch_end_out, input ready);
  modport sink   (input valid, arc_distance, batch_end_out, output ready);
endinterface

// ===== design/great_circle_distance_top.sv =====
// Great circle distance by the spherical law of cosines, fully pipelined.
// Throughput: one item per cycle while unstalled, set by the CORDIC and root cell chains.
// A stalled output item holds the whole pipeline; with no item waiting it keeps moving.
// Reset clears all valid flags and loads the radius with 1630978 (1/256 km).
module great_circle_distance_top #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gcd_in_if.sink      in_i,
  gcd_out_if.source   out_o,
  input  logic        sphere_radius_we_i,
  input  logic [23:0] sphere_radius_i
);

`include "great_circle_distance_top_macros.svh"

  localparam int N          = CORDIC_STAGES;
  localparam int ST_S2      = 2;
  localparam int ST_ROT     = 4;
  localparam int ST_ROT_END = ST_ROT + N;
  localparam int ST_M3      = ST_ROT_END + 3;
  localparam int ST_M4      = ST_ROT_END + 4;
  localparam int ST_SQ_END  = ST_M4 + gcd_pkg::SQRT_STAGES;
  localparam int ST_V0      = ST_SQ_END + 1;
  localparam int ST_VEC_END = ST_V0 + N;
  localparam int LAST       = ST_VEC_END + 2;

  // wrap into [-180, 180) degrees
  function automatic gcd_pkg::deg_t wrap_turn(input gcd_pkg::deg_t d);
    gcd_pkg::deg_t r;
    if (d < -gcd_pkg::FULL_TURN)   r = d + (gcd_pkg::FULL_TURN <<< 1);
    else if (d < 0)                r = d + gcd_pkg::FULL_TURN;
    else if (d >= gcd_pkg::FULL_TURN) r = d - gcd_pkg::FULL_TURN;
    else                           r = d;
    if (r >= gcd_pkg::HALF_TURN) r = r - gcd_pkg::FULL_TURN;
    return r;
  endfunction

  logic adv;
  logic [LAST:0] vld_q;
  gcd_pkg::sb_t  sb_q [LAST+1];
  gcd_pkg::sb_t  sb_s2_w, sb_m3_w;
  logic [23:0]   radius_q;

  gcd_pkg::deg_t      ang0_q [3];
  gcd_pkg::deg_t      norm_q [3];
  logic [22:0]        mag_q  [3];
  logic               sgn_q  [3];
  logic [22:0]        mag3_q [3];
  logic               sgn3_q [3];
  logic [53:0]        prod_q [3];
  gcd_pkg::cq_t       rot_w  [3][N+1];
  gcd_pkg::deg_t      fold_w [3];
  logic               fneg_w [3];

  logic signed [67:0] msb_q, mcc_q, mp2_q;
  gcd_pkg::ang_t      cd_q, ms_q;
  gcd_pkg::ang_t      s_w [3];
  gcd_pkg::ang_t      c_w [3];
  logic               neg_w [3];
  logic signed [34:0] sum_w;
  logic               big_w;
  logic signed [31:0] c3_q;
  logic signed [63:0] cc_w;
  gcd_pkg::sq_t       sq_w [gcd_pkg::SQRT_STAGES+1];
  gcd_pkg::sq_t       sq_in_q;
  gcd_pkg::cq_t       vec_in_q, vec_in_d;
  gcd_pkg::cq_t       vec_w [N+1];
  gcd_pkg::ang_t      root_w;
  logic [31:0]        acos_w;
  logic [55:0]        d0_q;
  logic [55:0]        rnd_w;
  logic [25:0]        arc_q;

  // whole pipeline moves unless the output item is stuck
  assign adv        = !vld_q[LAST] || out_o.ready;
  assign in_i.ready = adv;

  // valid flags and radius register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      radius_q <= gcd_pkg::RADIUS_RESET;
    end else begin
      if (adv) vld_q <= {vld_q[LAST-1:0], in_i.valid};
      if (sphere_radius_we_i) radius_q <= sphere_radius_i;
    end
  end

  // angle fold into [-90, 90] with sign flip flag
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      fneg_w[l] = 1'b1;
      if (norm_q[l] > gcd_pkg::QUARTER_TURN)       fold_w[l] = norm_q[l] - gcd_pkg::HALF_TURN;
      else if (norm_q[l] < -gcd_pkg::QUARTER_TURN) fold_w[l] = norm_q[l] + gcd_pkg::HALF_TURN;
      else begin
        fold_w[l] = norm_q[l];
        fneg_w[l] = 1'b0;
      end
    end
  end

  // sideband stages that pick up new flags
  always_comb begin
    sb_s2_w       = sb_q[ST_S2-1];
    sb_s2_w.neg_a = fneg_w[0];
    sb_s2_w.neg_b = fneg_w[1];
    sb_s2_w.neg_d = fneg_w[2];
    sb_m3_w       = sb_q[ST_M3-1];
    sb_m3_w.zero  = sb_q[ST_M3-1].zero || big_w;
  end

  // sideband flags
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_q[0].batch_end <= in_i.batch_end;
      sb_q[0].zero      <= (in_i.lon_a == in_i.lon_b) && (in_i.lat_a == in_i.lat_b);
      sb_q[0].neg_a     <= 1'b0;
      sb_q[0].neg_b     <= 1'b0;
      sb_q[0].neg_d     <= 1'b0;
      for (int k = 1; k <= LAST; k++) begin
        if (k == ST_S2)      sb_q[k] <= sb_s2_w;
        else if (k == ST_M3) sb_q[k] <= sb_m3_w;
        else                 sb_q[k] <= sb_q[k-1];
      end
    end
  end

  // front end: wrap, fold, degrees to radians
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ang0_q[0] <= gcd_pkg::DW'(in_i.lat_a);
      ang0_q[1] <= gcd_pkg::DW'(in_i.lat_b);
      ang0_q[2] <= gcd_pkg::DW'(in_i.lon_b) - gcd_pkg::DW'(in_i.lon_a);
      for (int l = 0; l < 3; l++) begin
        norm_q[l] <= wrap_turn(ang0_q[l]);
        sgn_q[l]  <= fold_w[l] < 0;
        mag_q[l]  <= (fold_w[l] < 0) ? 23'(-fold_w[l]) : 23'(fold_w[l]);
        mag3_q[l] <= mag_q[l];
        sgn3_q[l] <= sgn_q[l];
        prod_q[l] <= 54'(mag_q[l]) * 54'(gcd_pkg::DEG2RAD_LO);
      end
    end
  end

  // rotation CORDIC lanes: lat_a, lat_b, lon difference
  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [57:0]   rsum;
    gcd_pkg::ang_t zin;
    gcd_pkg::cq_t  rot_in_q;

    assign rsum = (58'(mag3_q[l]) << gcd_pkg::DEG2RAD_HI) + 58'(prod_q[l]) + (58'(1) << 25);
    assign zin  = sgn3_q[l] ? -gcd_pkg::ang_t'(rsum[57:26]) : gcd_pkg::ang_t'(rsum[57:26]);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rot_in_q.x <= gcd_pkg::GAIN_Q30;
        rot_in_q.y <= '0;
        rot_in_q.z <= zin;
      end
    end

    assign rot_w[l][0] = rot_in_q;

    for (genvar k = 0; k < N; k++) begin : g_cell
      gcd_rot_cell #(.STAGE(k)) u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .d_i   (rot_w[l][k]),
        .q_o   (rot_w[l][k+1])
      );
    end
  end

  // restore signs of the folded angles
  always_comb begin
    neg_w[0] = sb_q[ST_ROT_END].neg_a;
    neg_w[1] = sb_q[ST_ROT_END].neg_b;
    neg_w[2] = sb_q[ST_ROT_END].neg_d;
    for (int l = 0; l < 3; l++) begin
      s_w[l] = neg_w[l] ? -rot_w[l][N].y : rot_w[l][N].y;
      c_w[l] = neg_w[l] ? -rot_w[l][N].x : rot_w[l][N].x;
    end
  end

  // cosine sum and 1 - c^2
  assign sum_w = 35'(ms_q) + 35'(gcd_pkg::ang_t'(mp2_q >>> 30));
  assign big_w = sum_w >= 35'(gcd_pkg::ONE_Q30);
  assign cc_w  = 64'(c3_q) * 64'(c3_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      msb_q <= 68'(s_w[0]) * 68'(s_w[1]);
      mcc_q <= 68'(c_w[0]) * 68'(c_w[1]);
      cd_q  <= c_w[2];
      ms_q  <= gcd_pkg::ang_t'(msb_q >>> 30);
      mp2_q <= 68'(gcd_pkg::ang_t'(mcc_q >>> 30)) * 68'(cd_q);
      c3_q  <= (sum_w < -35'(gcd_pkg::ONE_Q30)) ? -32'sd1073741824 : 32'(sum_w);
      sq_in_q.v   <= (gcd_pkg::SQW'(1) << 60) - gcd_pkg::SQW'(cc_w);
      sq_in_q.res <= '0;
      sq_in_q.c   <= c3_q;
    end
  end

  // square root chain
  assign sq_w[0] = sq_in_q;
  for (genvar k = 0; k < gcd_pkg::SQRT_STAGES; k++) begin : g_sqrt
    gcd_sqrt_cell #(.STAGE(k)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .d_i   (sq_w[k]),
      .q_o   (sq_w[k+1])
    );
  end

  // arccos setup: start in the right half plane
  always_comb begin
    root_w = gcd_pkg::ang_t'(sq_w[gcd_pkg::SQRT_STAGES].res);
    if (sq_w[gcd_pkg::SQRT_STAGES].c < 0) begin
      vec_in_d.x = root_w;
      vec_in_d.y = -gcd_pkg::ang_t'(sq_w[gcd_pkg::SQRT_STAGES].c);
      vec_in_d.z = gcd_pkg::HALF_PI_Q30;
    end else begin
      vec_in_d.x = gcd_pkg::ang_t'(sq_w[gcd_pkg::SQRT_STAGES].c);
      vec_in_d.y = root_w;
      vec_in_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) vec_in_q <= vec_in_d;
  end

  assign vec_w[0] = vec_in_q;
  for (genvar k = 0; k < N; k++) begin : g_vec
    gcd_vec_cell #(.STAGE(k)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .d_i   (vec_w[k]),
      .q_o   (vec_w[k+1])
    );
  end

  // clamp angle to [0, pi], scale by radius, round
  always_comb begin
    if (vec_w[N].z < 0)                     acos_w = '0;
    else if (vec_w[N].z > gcd_pkg::PI_Q30)  acos_w = 32'(gcd_pkg::PI_Q30);
    else                                    acos_w = 32'(vec_w[N].z);
  end

  assign rnd_w = d0_q + (56'(1) << 29);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d0_q  <= 56'(acos_w) * 56'(radius_q);
      arc_q <= sb_q[LAST-1].zero ? '0 : rnd_w[55:30];
    end
  end

  assign out_o.valid         = vld_q[LAST];
  assign out_o.arc_distance  = arc_q;
  assign out_o.batch_end_out = sb_q[LAST].batch_end;

  `GCD_ASSERT(a_zero_out, (vld_q[LAST] && sb_q[LAST].zero) |-> (arc_q == '0), "zero flag but nonzero distance")
  `GCD_ASSERT(a_root_range, (vld_q[ST_SQ_END] && !sb_q[ST_SQ_END].zero) |-> (sq_w[gcd_pkg::SQRT_STAGES].res <= (62'(1) << 30)), "root above one")
  `GCD_ASSERT(a_vec_right, vld_q[ST_V0] |-> !vec_in_q.x[gcd_pkg::AW-1], "arccos start in left half plane")
  `GCD_ASSERT_RST(a_rst_idle, !rst_ni |-> !out_o.valid, "output valid during reset")

endmodule

// ===== design/gcd_rot_cell.sv =====
// One rotation-mode CORDIC cell (sine/cosine), registered output.
// Depends on gcd_pkg.
module gcd_rot_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  gcd_pkg::cq_t d_i,
  output gcd_pkg::cq_t q_o
);

  gcd_pkg::cq_t cell_d, cell_q;

  // rotate toward z = 0
  always_comb begin
    if (d_i.z >= 0) begin
      cell_d.x = d_i.x - (d_i.y >>> STAGE);
      cell_d.y = d_i.y + (d_i.x >>> STAGE);
      cell_d.z = d_i.z - gcd_pkg::atan_q30(STAGE);
    end else begin
      cell_d.x = d_i.x + (d_i.y >>> STAGE);
      cell_d.y = d_i.y - (d_i.x >>> STAGE);
      cell_d.z = d_i.z + gcd_pkg::atan_q30(STAGE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign q_o = cell_q;

endmodule

// ===== design/gcd_vec_cell.sv =====
// One vectoring-mode CORDIC cell (arctangent), registered output.
// Depends on gcd_pkg.
module gcd_vec_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  gcd_pkg::cq_t d_i,
  output gcd_pkg::cq_t q_o
);

  gcd_pkg::cq_t cell_d, cell_q;

  // drive y toward zero, accumulate angle
  always_comb begin
    if (d_i.y > 0) begin
      cell_d.x = d_i.x + (d_i.y >>> STAGE);
      cell_d.y = d_i.y - (d_i.x >>> STAGE);
      cell_d.z = d_i.z + gcd_pkg::atan_q30(STAGE);
    end else begin
      cell_d.x = d_i.x - (d_i.y >>> STAGE);
      cell_d.y = d_i.y + (d_i.x >>> STAGE);
      cell_d.z = d_i.z - gcd_pkg::atan_q30(STAGE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign q_o = cell_q;

endmodule

// ===== design/gcd_sqrt_cell.sv =====
// One digit step of a restoring integer square root, registered output.
// Depends on gcd_pkg.
module gcd_sqrt_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  gcd_pkg::sq_t d_i,
  output gcd_pkg::sq_t q_o
);

  localparam logic [gcd_pkg::SQW-1:0] BIT =
    gcd_pkg::SQW'(1) << (2 * (gcd_pkg::SQRT_STAGES - 1 - STAGE));

  gcd_pkg::sq_t        cell_d, cell_q;
  logic [gcd_pkg::SQW-1:0] trial;

  // subtract trial if it fits, shift root
  always_comb begin
    trial    = d_i.res + BIT;
    cell_d.c = d_i.c;
    if (d_i.v >= trial) begin
      cell_d.v   = d_i.v - trial;
      cell_d.res = (d_i.res >> 1) + BIT;
    end else begin
      cell_d.v   = d_i.v;
      cell_d.res = d_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign q_o = cell_q;

endmodule

// ===== tb/great_circle_distance_top_test.sv =====
// Testbench for great_circle_distance_top: directed and random coordinate items,
// checked against a fixed-point distance predictor. Depends on gcd_pkg and gcd_if.
module great_circle_distance_top_test;

  localparam int     STAGES      = 24;
  localparam int     LATENCY     = 2 * STAGES + 42;
  localparam int     STALL_LIMIT = 5000;
  localparam longint ONE         = 64'sd1073741824;
  localparam longint PI_ANG      = 64'sd3373259426;
  localparam longint HALF_PI_ANG = 64'sd1686629713;
  localparam longint GAIN        = 64'sd652032874;
  localparam longint TURN        = 64'sd23592960;
  localparam longint HALF        = 64'sd11796480;
  localparam longint QUARTER     = 64'sd5898240;
  localparam longint LON_MAX     = 64'sd11796480;
  localparam longint LAT_MAX     = 64'sd5898240;
  localparam longint unsigned RAD_PER_DEG = 64'd19190098069;

  typedef struct packed {
    logic signed [24:0] lon_a;
    logic signed [23:0] lat_a;
    logic signed [24:0] lon_b;
    logic signed [23:0] lat_b;
    logic               batch_end;
  } coord_t;

  typedef struct packed {
    logic [25:0] arc_distance;
    logic        batch_end_out;
  } dist_t;

  logic        clk_i;
  logic        rst_ni;
  logic        sphere_radius_we_i;
  logic [23:0] sphere_radius_i;
  logic [23:0] radius_model;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          fail_count;
  int          quiet_cycles;
  dist_t       expected_dist_q[$];

  gcd_in_if  in_if();
  gcd_out_if out_if();

  great_circle_distance_top #(.CORDIC_STAGES(STAGES)) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_i               (in_if),
    .out_o              (out_if),
    .sphere_radius_we_i (sphere_radius_we_i),
    .sphere_radius_i    (sphere_radius_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // atan(2^-i) in Q30
  function automatic longint arctan_step(int i);
    longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return head[i];
    if (i <= 30) return longint'(1) << (30 - i);
    return 0;
  endfunction

  // rotation CORDIC on an angle in 1/65536 degree
  function automatic void sine_cosine(input longint d, output longint s, output longint c);
    longint r, z, x, y, nx;
    longint unsigned m, rad;
    bit flip;
    r = d % TURN;
    flip = 1'b0;
    if (r < 0) r += TURN;
    if (r >= HALF) r -= TURN;
    if (r > QUARTER) begin
      r -= HALF;
      flip = 1'b1;
    end else if (r < -QUARTER) begin
      r += HALF;
      flip = 1'b1;
    end
    m = (r < 0) ? -r : r;
    rad = (m * RAD_PER_DEG + (64'd1 << 25)) >> 26;
    z = (r < 0) ? -longint'(rad) : longint'(rad);
    x = GAIN;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_step(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_step(i);
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // vectoring CORDIC: acos(c) = atan2(sqrt(1-c^2), c), clamped to [0, pi]
  function automatic longint arc_cosine(longint c);
    longint x, y, z, nx, t;
    y = longint'(int_sqrt((64'd1 << 60) - longint'(c * c)));
    x = c;
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = HALF_PI_ANG;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_step(i);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_step(i);
      end
      x = nx;
    end
    if (z < 0) z = 0;
    if (z > PI_ANG) z = PI_ANG;
    return z;
  endfunction

  function automatic dist_t predict_distance(coord_t p, logic [23:0] radius);
    longint sa, ca, sb, cb, sd, cd, sum;
    longint unsigned arc_len;
    dist_t d;
    arc_len = 0;
    if (!(p.lon_a == p.lon_b && p.lat_a == p.lat_b)) begin
      sine_cosine(longint'(p.lat_a), sa, ca);
      sine_cosine(longint'(p.lat_b), sb, cb);
      sine_cosine(longint'(p.lon_b) - longint'(p.lon_a), sd, cd);
      sum = ((sa * sb) >>> 30) + ((((ca * cb) >>> 30) * cd) >>> 30);
      if (sum < ONE) begin
        if (sum < -ONE) sum = -ONE;
        arc_len = (longint'(arc_cosine(sum)) * longint'(radius) + (64'd1 << 29)) >> 30;
      end
    end
    d.arc_distance = arc_len[25:0];
    d.batch_end_out = p.batch_end;
    return d;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    dist_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_dist_q.size() == 0) begin
        report_mismatch("unexpected item", out_if.arc_distance, -1);
      end else begin
        want = expected_dist_q.pop_front();
        if (out_if.arc_distance !== want.arc_distance)
          report_mismatch("arc_distance", out_if.arc_distance, want.arc_distance);
        if (out_if.batch_end_out !== want.batch_end_out)
          report_mismatch("batch_end_out", out_if.batch_end_out, want.batch_end_out);
      end
    end
  end

  // receiver backpressure
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // send one item; called at a falling edge, returns at a falling edge
  task automatic send_coords(coord_t p);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.lon_a     <= p.lon_a;
    in_if.lat_a     <= p.lat_a;
    in_if.lon_b     <= p.lon_b;
    in_if.lat_b     <= p.lat_b;
    in_if.batch_end <= p.batch_end;
    do @(posedge clk_i); while (!in_if.ready);
    expected_dist_q.push_back(predict_distance(p, radius_model));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_dist_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  task automatic write_radius(logic [23:0] r);
    wait_drained();
    sphere_radius_we_i <= 1'b1;
    sphere_radius_i    <= r;
    @(negedge clk_i);
    sphere_radius_we_i <= 1'b0;
    radius_model = r;
  endtask

  function automatic coord_t make_coords(longint lo_a, longint la_a, longint lo_b,
                                         longint la_b, bit last);
    coord_t p;
    p.lon_a = lo_a[24:0];
    p.lat_a = la_a[23:0];
    p.lon_b = lo_b[24:0];
    p.lat_b = la_b[23:0];
    p.batch_end = last;
    return p;
  endfunction

  // mostly legal coordinates, some raw bit patterns beyond the legal range
  function automatic coord_t random_coords();
    coord_t p;
    if ($urandom_range(9) < 2) begin
      p = $bits(coord_t)'({$urandom, $urandom, $urandom, $urandom});
    end else begin
      p = make_coords(longint'($urandom_range(32'(2 * LON_MAX))) - LON_MAX,
                      longint'($urandom_range(32'(2 * LAT_MAX))) - LAT_MAX,
                      longint'($urandom_range(32'(2 * LON_MAX))) - LON_MAX,
                      longint'($urandom_range(32'(2 * LAT_MAX))) - LAT_MAX,
                      1'($urandom_range(1)));
      // near-identical or identical points
      case ($urandom_range(9))
        0: begin
          p.lon_b = p.lon_a;
          p.lat_b = p.lat_a;
        end
        1: p.lon_b = p.lon_a + $signed(25'($urandom_range(8))) - 25'sd4;
        default: ;
      endcase
    end
    return p;
  endfunction

  task automatic test_directed();
    send_coords(make_coords(0, 0, 0, 0, 0));
    send_coords(make_coords(12345, -6789, 12345, -6789, 1));
    send_coords(make_coords(0, 0, LON_MAX, 0, 0));             // antipodes
    send_coords(make_coords(-LON_MAX, 0, LON_MAX, 0, 1));      // same point, 360 apart
    send_coords(make_coords(0, LAT_MAX, 0, -LAT_MAX, 0));      // pole to pole
    send_coords(make_coords(-LON_MAX, -LAT_MAX, LON_MAX, LAT_MAX, 1));
    send_coords(make_coords(LON_MAX, LAT_MAX, -LON_MAX, -LAT_MAX, 0));
    send_coords(make_coords(0, LAT_MAX, 5000000, LAT_MAX, 0)); // both at a pole
    send_coords(make_coords(0, 0, 1, 0, 1));                   // smallest step
    send_coords(make_coords(0, 0, 0, 1, 0));
    send_coords(make_coords(-16777216, -8388608, 16777215, 8388607, 1));
    send_coords(make_coords(16777215, 8388607, -16777216, -8388608, 0));
    send_coords(make_coords(0, 0, QUARTER, 0, 0));
    send_coords(make_coords(-QUARTER, 0, QUARTER, 0, 1));
    send_coords(make_coords(0, 0, HALF - 1, 0, 0));            // almost antipodal
    send_coords(make_coords(1000000, -3000000, -9000000, 2000000, 1));
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_coords(random_coords());
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
  endtask

  // sender holds off until the pipeline has emptied, then resumes
  task automatic test_drain_pause();
    repeat (20) send_coords(random_coords());
    in_if.valid <= 1'b0;
    while (expected_dist_q.size() != 0) @(negedge clk_i);
    repeat (20) send_coords(random_coords());
  endtask

  task automatic test_radius_settings();
    logic [23:0] radii[5] = '{24'd1, 24'hFFFFFF, 24'd0, 24'd6371 * 24'd256, 24'd777};
    foreach (radii[k]) begin
      write_radius(radii[k]);
      test_directed();
      test_random(40, 24, 24);
    end
    write_radius(gcd_pkg::RADIUS_RESET);
  endtask

  initial begin
    fail_count         = 0;
    quiet_cycles       = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    radius_model       = gcd_pkg::RADIUS_RESET;
    rst_ni             = 1'b0;
    sphere_radius_we_i = 1'b0;
    sphere_radius_i    = '0;
    out_if.ready       = 1'b0;
    in_if.valid        = 1'b0;
    in_if.lon_a        = '0;
    in_if.lat_a        = '0;
    in_if.lon_b        = '0;
    in_if.lat_b        = '0;
    in_if.batch_end    = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(120, 0, 0);
    test_random(120, 68, 0);
    test_random(120, 0, 68);
    test_random(120, 24, 24);
    test_drain_pause();
    test_radius_settings();
    test_random(100, 0, 0);

    wait_drained();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/gcd_pkg.sv
design/gcd_if.sv
design/gcd_rot_cell.sv
design/gcd_vec_cell.sv
design/gcd_sqrt_cell.sv
design/great_circle_distance_top.sv
tb/great_circle_distance_top_test.sv
